// File: design/char_lcd_shadow_refresh_assert.svh
// assertion macros shared by the char lcd shadow refresh modules
`ifndef CHAR_LCD_SHADOW_REFRESH_ASSERT_SVH
`define CHAR_LCD_SHADOW_REFRESH_ASSERT_SVH

// same-cycle implication, checked outside reset
`define CLSR_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("clsr assertion failed");

// next-cycle implication, checked outside reset
`define CLSR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("clsr assertion failed");

`endif

// File: design/clsr_pkg.sv
// types, codes and tables shared by the char lcd shadow refresh modules
package clsr_pkg;

    // screen geometry defaults and fixed row stride of the buffer
    localparam int ROWS_DEF = 4;
    localparam int COLS_DEF = 16;
    localparam int STRIDE   = 16;

    // request command codes
    localparam logic [1:0] CMD_WRITE_POS = 2'd0;
    localparam logic [1:0] CMD_WRITE_CUR = 2'd1;
    localparam logic [1:0] CMD_REFRESH   = 2'd2;
    localparam logic [1:0] CMD_CLEAR     = 2'd3;

    // operation codes on the queue between front and back
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // blank character
    localparam logic [7:0] SPACE_CHAR = 8'h20;

    // operation queue size
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [1:0] cmd;
        logic [1:0] row_sel;
        logic [3:0] col_sel;
        logic [7:0] char_code;
    } in_item_t;

    typedef struct packed {
        logic       is_data;
        logic [7:0] lcd_byte;
        logic       last_of_pair;
    } out_item_t;

    typedef struct packed {
        logic [1:0] row;
        logic [3:0] col;
    } pos_t;

    // one queued operation: write char, read for refresh, or clear
    typedef struct packed {
        logic [1:0] op;
        pos_t       pos;
        logic [7:0] data;
    } op_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    // ddram base address of each row
    function automatic logic [7:0] row_base(input logic [1:0] row);
        logic [7:0] base;
        case (row)
            2'd0:    base = 8'h80;
            2'd1:    base = 8'hC0;
            2'd2:    base = 8'h90;
            default: base = 8'hD0;
        endcase
        return base;
    endfunction

endpackage

// File: design/clsr_front.sv
// front end: accepts requests, keeps the cursors, turns requests into buffer operations
module clsr_front #(
    parameter int ROWS = clsr_pkg::ROWS_DEF,
    parameter int COLS = clsr_pkg::COLS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  clsr_pkg::in_item_t     s_data,
    output logic                   q_push,
    output clsr_pkg::op_entry_t    q_entry,
    input  clsr_pkg::queue_stat_t  q_stat
);

    localparam logic [2:0] ROWS_W = 3'(ROWS);
    localparam logic [4:0] COLS_W = 5'(COLS);

    clsr_pkg::pos_t wr_pos_reg, wr_pos_next;
    clsr_pkg::pos_t scan_pos_reg, scan_pos_next;
    logic           accept;

    // column then row wrap of a cursor
    function automatic clsr_pkg::pos_t advance(input clsr_pkg::pos_t p);
        clsr_pkg::pos_t n;
        logic [4:0]     col_inc;
        logic [2:0]     row_inc;
        col_inc = {1'b0, p.col} + 5'd1;
        row_inc = {1'b0, p.row} + 3'd1;
        n = p;
        if (col_inc >= COLS_W) begin
            n.col = '0;
            n.row = (row_inc >= ROWS_W) ? 2'd0 : row_inc[1:0];
        end else begin
            n.col = col_inc[3:0];
        end
        return n;
    endfunction

    assign s_ready = !q_stat.full;
    assign accept  = s_valid && s_ready;

    // classify the request
    always_comb begin
        wr_pos_next   = wr_pos_reg;
        scan_pos_next = scan_pos_reg;
        q_push        = 1'b0;
        q_entry.op    = clsr_pkg::OP_CLEAR;
        q_entry.pos   = '{row: s_data.row_sel, col: s_data.col_sel};
        q_entry.data  = s_data.char_code;
        case (s_data.cmd)
            clsr_pkg::CMD_WRITE_POS: begin
                // off-screen positions are dropped
                if (({1'b0, s_data.row_sel} < ROWS_W) && ({1'b0, s_data.col_sel} < COLS_W)) begin
                    q_push      = accept;
                    q_entry.op  = clsr_pkg::OP_WRITE;
                    if (accept) begin
                        wr_pos_next = advance(q_entry.pos);
                    end
                end
            end
            clsr_pkg::CMD_WRITE_CUR: begin
                q_push      = accept;
                q_entry.op  = clsr_pkg::OP_WRITE;
                q_entry.pos = wr_pos_reg;
                if (accept) begin
                    wr_pos_next = advance(wr_pos_reg);
                end
            end
            clsr_pkg::CMD_REFRESH: begin
                q_push       = accept;
                q_entry.op   = clsr_pkg::OP_READ;
                q_entry.pos  = scan_pos_reg;
                q_entry.data = clsr_pkg::row_base(scan_pos_reg.row) | {4'd0, scan_pos_reg.col};
                if (accept) begin
                    scan_pos_next = advance(scan_pos_reg);
                end
            end
            default: begin
                q_push     = accept;
                q_entry.op = clsr_pkg::OP_CLEAR;
            end
        endcase
    end

    // cursor registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_pos_reg   <= '0;
            scan_pos_reg <= '0;
        end else begin
            wr_pos_reg   <= wr_pos_next;
            scan_pos_reg <= scan_pos_next;
        end
    end

endmodule

// File: design/clsr_fifo.sv
// short operation queue between the front end and the buffer engine
module clsr_fifo (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  clsr_pkg::op_entry_t    push_entry,
    input  logic                   pop,
    output clsr_pkg::op_entry_t    head,
    output clsr_pkg::queue_stat_t  stat
);

    `include "char_lcd_shadow_refresh_assert.svh"

    localparam int AW = clsr_pkg::QUEUE_AW;
    localparam logic [AW:0] DEPTH_W = (AW + 1)'(clsr_pkg::QUEUE_DEPTH);

    clsr_pkg::op_entry_t entry_reg [clsr_pkg::QUEUE_DEPTH];
    logic [AW-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]         count_reg;

    assign head       = entry_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == DEPTH_W);
    assign stat.empty = (count_reg == '0);

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + (AW + 1)'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - (AW + 1)'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    `CLSR_ASSERT_IMP(a_no_overflow, aclk, aresetn, push && !pop, !stat.full)
    `CLSR_ASSERT_IMP(a_no_underflow, aclk, aresetn, pop, !stat.empty)

endmodule

// File: design/clsr_back.sv
// back end: applies queued operations to the shadow buffer and sends refresh byte pairs
module clsr_back #(
    parameter int ROWS = clsr_pkg::ROWS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  clsr_pkg::op_entry_t    q_head,
    input  clsr_pkg::queue_stat_t  q_stat,
    output logic                   q_pop,
    output logic                   m_valid,
    input  logic                   m_ready,
    output clsr_pkg::out_item_t    m_data
);

    `include "char_lcd_shadow_refresh_assert.svh"

    localparam int DEPTH = ROWS * clsr_pkg::STRIDE;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMD  = 2'd1;
    localparam logic [1:0] ST_DATA = 2'd2;

    logic [1:0]          state_reg, state_next;
    clsr_pkg::out_item_t out_reg, out_next;
    logic [7:0]          mem [DEPTH];
    logic [DEPTH-1:0]    cell_valid_reg;
    logic [7:0]          rd_data_reg;
    logic                rd_valid_reg;
    logic [5:0]          cell_idx;
    logic [AW-1:0]       addr;
    logic                mem_we, mem_re, clear_all;

    assign cell_idx = {q_head.pos.row, q_head.pos.col};
    assign addr     = cell_idx[AW-1:0];
    assign m_valid  = (state_reg != ST_IDLE);
    assign m_data   = out_reg;

    // sequencer
    always_comb begin
        state_next = state_reg;
        out_next   = out_reg;
        q_pop      = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        clear_all  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (!q_stat.empty) begin
                    q_pop = 1'b1;
                    case (q_head.op)
                        clsr_pkg::OP_WRITE: begin
                            mem_we = 1'b1;
                        end
                        clsr_pkg::OP_READ: begin
                            mem_re     = 1'b1;
                            out_next   = '{is_data: 1'b0, lcd_byte: q_head.data,
                                           last_of_pair: 1'b0};
                            state_next = ST_CMD;
                        end
                        default: begin
                            clear_all = 1'b1;
                        end
                    endcase
                end
            end
            ST_CMD: begin
                if (m_ready) begin
                    out_next   = '{is_data: 1'b1,
                                   lcd_byte: rd_valid_reg ? rd_data_reg : clsr_pkg::SPACE_CHAR,
                                   last_of_pair: 1'b1};
                    state_next = ST_DATA;
                end
            end
            ST_DATA: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    // written marks: an unmarked cell reads as a space
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_valid_reg <= '0;
        end else if (clear_all) begin
            cell_valid_reg <= '0;
        end else if (mem_we) begin
            cell_valid_reg[addr] <= 1'b1;
        end
    end

    // character memory with registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[addr] <= q_head.data;
        end
        if (mem_re) begin
            rd_data_reg  <= mem[addr];
            rd_valid_reg <= cell_valid_reg[addr];
        end
    end

    `CLSR_ASSERT_NEXT(a_data_follows_cmd, aclk, aresetn, m_valid && m_ready && !m_data.is_data, m_valid && m_data.is_data)
    `CLSR_ASSERT_IMP(a_last_on_data, aclk, aresetn, m_valid, m_data.last_of_pair == m_data.is_data)
    `CLSR_ASSERT_IMP(a_pop_when_idle, aclk, aresetn, q_pop, !m_valid)

endmodule

// File: design/char_lcd_shadow_refresh.sv
// character lcd shadow buffer, top level; each refresh request sends a single cell
// a write or clear lands in the buffer when the back end pops it from the operation queue
// a refresh tick's command byte is valid from the edge at which the back end pops it, the data byte
// in the cycle after the command byte is taken; no further operation is popped until both are taken
// a request is taken whenever the 2-entry operation queue has room
// reset (aresetn low, synchronous) zeroes both cursors and marks every cell blank at once
module char_lcd_shadow_refresh #(
    parameter int ROWS = clsr_pkg::ROWS_DEF,
    parameter int COLS = clsr_pkg::COLS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  clsr_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output clsr_pkg::out_item_t  m_data
);

    logic                  q_push, q_pop;
    clsr_pkg::op_entry_t   q_entry, q_head;
    clsr_pkg::queue_stat_t q_stat;

    // request decode and cursors
    clsr_front #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_push  (q_push),
        .q_entry (q_entry),
        .q_stat  (q_stat)
    );

    // operation queue
    clsr_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head       (q_head),
        .stat       (q_stat)
    );

    // buffer engine and lcd byte output
    clsr_back #(
        .ROWS (ROWS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_head  (q_head),
        .q_stat  (q_stat),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
